// ===== rtl/lmdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdt_pkg
// Shared types and constants of the longest-match DFA tokenizer.
// ----------------------------------------------------------------------------
package lmdt_pkg;

   localparam int unsigned NUM_STATES      = 64;
   localparam int unsigned MAX_LOOKAHEAD   = 16;
   localparam int unsigned NUM_TOKEN_TYPES = 64;

   localparam int unsigned STATE_W   = 6;
   localparam int unsigned SYM_W     = 8;
   localparam int unsigned TYPE_W    = 6;
   localparam int unsigned LEN_W     = 5;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned LA_IDX_W  = $clog2(MAX_LOOKAHEAD);
   localparam int unsigned TT_ADDR_W = STATE_W + SYM_W;
   localparam int unsigned TT_DEPTH  = NUM_STATES * (1 << SYM_W);
   localparam int unsigned CLR_W     = TT_ADDR_W + 1;
   localparam int unsigned CSR_ADDR_W = 2;

   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EDGE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_INFO = 2'd3;

   localparam logic [KIND_W-1:0] RES_TOKEN = 2'd0;
   localparam logic [KIND_W-1:0] RES_ERROR = 2'd1;
   localparam logic [KIND_W-1:0] RES_END   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_START_STATE = 2'd0;

   localparam logic [SYM_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [SYM_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [SYM_W-1:0] CH_TAB     = 8'h09;
   localparam logic [SYM_W-1:0] CH_CR      = 8'h0D;

   typedef enum logic [2:0] {
      OP_CHAR,
      OP_END,
      OP_EDGE,
      OP_INFO,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SYM_W-1:0]    symbol;
      logic [STATE_W-1:0]  table_state;
      logic [STATE_W-1:0]  target_state;
      logic                edge_present;
      logic                accepting;
      logic [TYPE_W-1:0]   accepted_type;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [TYPE_W-1:0]   token_type;
      logic [LEN_W-1:0]    token_length;
      logic [POS_W-1:0]    start_line;
      logic [POS_W-1:0]    start_column;
      logic [SYM_W-1:0]    bad_symbol;
      logic                last;
   } result_type;

   function automatic logic is_blank(input logic [SYM_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NEWLINE);
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v == {POS_W{1'b1}}) ? v : POS_W'(v + POS_W'(1));
   endfunction

endpackage

// ===== rtl/longest_match_dfa_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_match_dfa_tokenizer_unit
// Table-driven longest-match lexer with a loadable DFA.
//
// Items enter on the req_ channel (valid/ready): characters, end of input,
// and writes of the transition and accept tables. Results leave on the rsp_
// channel (valid/ready), one transfer per result; rsp_last marks the final
// result of an item. start_state sits in a register on the csr_ port.
// A character goes through a transition-table read, then the decision.
// Emitting a token pushes its result and then consumes its characters;
// the remaining buffered characters are walked again through the table.
// A four-entry path (2-deep input queue, hold stage, output register)
// lets input keep flowing while a result waits. After reset both tables
// are cleared by a sweep over all 16384 transition entries, one per
// cycle; items queue up but are not processed until the sweep ends.
// When rsp_ready is low the engine stalls once its hold stage and
// output register are full, and req_ready drops when the queue fills.
// ----------------------------------------------------------------------------
module longest_match_dfa_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_symbol,
   input  logic [5:0]  req_table_state,
   input  logic [5:0]  req_target_state,
   input  logic        req_edge_present,
   input  logic        req_accepting,
   input  logic [5:0]  req_accepted_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [5:0]  rsp_token_type,
   output logic [4:0]  rsp_token_length,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [7:0]  rsp_bad_symbol,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [5:0] start_state_ff, start_state_in;
   logic       csr_wr, head_valid, pop;
   lmdt_pkg::item_type   head;
   lmdt_pkg::result_type rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == lmdt_pkg::CSR_START_STATE);

   always_comb begin
      start_state_in = csr_wr ? csr_pwdata[5:0] : start_state_ff;
      csr_prdata     = (csr_paddr == lmdt_pkg::CSR_START_STATE) ?
                       {26'd0, start_state_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
      end else begin
         start_state_ff <= start_state_in;
      end
   end

   lmdt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_symbol        (req_symbol),
      .req_table_state   (req_table_state),
      .req_target_state  (req_target_state),
      .req_edge_present  (req_edge_present),
      .req_accepting     (req_accepting),
      .req_accepted_type (req_accepted_type),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop)
   );

   lmdt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .start_state (start_state_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_result_kind  = rsp.result_kind;
   assign rsp_token_type   = rsp.token_type;
   assign rsp_token_length = rsp.token_length;
   assign rsp_start_line   = rsp.start_line;
   assign rsp_start_column = rsp.start_column;
   assign rsp_bad_symbol   = rsp.bad_symbol;
   assign rsp_last         = rsp.last;

endmodule

// ===== rtl/lmdt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdt_front
// Accepts input items, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
module lmdt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_symbol,
   input  logic [5:0]        req_table_state,
   input  logic [5:0]        req_target_state,
   input  logic              req_edge_present,
   input  logic              req_accepting,
   input  logic [5:0]        req_accepted_type,
   output logic              head_valid,
   output lmdt_pkg::item_type head,
   input  logic              pop
);

   lmdt_pkg::item_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   lmdt_pkg::item_type item;
   logic       push, ts_ok, ty_ok;

   always_comb begin
      ts_ok = 32'(req_table_state) < lmdt_pkg::NUM_STATES;
      ty_ok = 32'(req_accepted_type) < lmdt_pkg::NUM_TOKEN_TYPES;
      item.symbol        = req_symbol;
      item.table_state   = req_table_state;
      item.target_state  = req_target_state;
      item.edge_present  = req_edge_present;
      item.accepting     = req_accepting;
      item.accepted_type = req_accepted_type;
      unique case (req_kind)
         lmdt_pkg::KIND_CHAR: item.op = lmdt_pkg::OP_CHAR;
         lmdt_pkg::KIND_END:  item.op = lmdt_pkg::OP_END;
         lmdt_pkg::KIND_EDGE: item.op = ts_ok ? lmdt_pkg::OP_EDGE : lmdt_pkg::OP_NOP;
         lmdt_pkg::KIND_INFO: item.op = (ts_ok && ty_ok) ? lmdt_pkg::OP_INFO
                                                          : lmdt_pkg::OP_NOP;
         default:             item.op = lmdt_pkg::OP_NOP;
      endcase
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= item;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/lmdt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdt_back
// DFA walk engine: table memories, lookahead window, match tracking,
// replay after an emitted token, position tracking and result staging.
// ----------------------------------------------------------------------------
module lmdt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [5:0]                start_state,
   input  logic                      head_valid,
   input  lmdt_pkg::item_type        head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lmdt_pkg::result_type      rsp
);

   localparam int unsigned SW = lmdt_pkg::STATE_W;
   localparam int unsigned CW = lmdt_pkg::SYM_W;
   localparam int unsigned LW = lmdt_pkg::LEN_W;
   localparam int unsigned PW = lmdt_pkg::POS_W;
   localparam int unsigned IW = lmdt_pkg::LA_IDX_W;
   localparam int unsigned AW = lmdt_pkg::TT_ADDR_W;
   localparam int unsigned EW = SW + 1;
   localparam int unsigned IEW = SW + lmdt_pkg::TYPE_W - SW + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_LOOK,
      ST_EMIT,
      ST_CONS
   } state_type;

   logic [EW-1:0]  tt_mem [lmdt_pkg::TT_DEPTH];
   logic [IEW-1:0] si_mem [lmdt_pkg::NUM_STATES];
   logic [EW-1:0]  tt_rd_ff;
   logic [IEW-1:0] si_rd_ff;
   logic           tt_we, tt_re, si_we, si_re;
   logic [AW-1:0]  tt_waddr, tt_raddr;
   logic [EW-1:0]  tt_wdata;
   logic [SW-1:0]  si_waddr, si_raddr;
   logic [IEW-1:0] si_wdata;

   state_type state_ff, state_in;
   logic [lmdt_pkg::CLR_W-1:0] clr_ff, clr_in;
   logic [IW-1:0] h_ff, h_in;
   logic [LW-1:0] bc_ff, bc_in, np_ff, np_in, cnt_ff, cnt_in;
   logic [SW-1:0] walk_ff, walk_in;
   logic [LW-1:0] mlen_ff, mlen_in, si_len_ff, si_len_in;
   logic [lmdt_pkg::TYPE_W-1:0] mtype_ff, mtype_in;
   logic [PW-1:0] line_ff, line_in, col_ff, col_in, tline_ff, tline_in, tcol_ff, tcol_in;
   logic [CW-1:0] c_ff, c_in;
   logic          sok_ff, sok_in, qsrc_ff, qsrc_in, owe_ff, owe_in, si_pend_ff, si_pend_in;
   logic [CW-1:0] buf_ff [lmdt_pkg::MAX_LOOKAHEAD];
   lmdt_pkg::result_type hold_ff, hold_in, rsp_ff, rsp_in, push_res, out_res;
   logic          hold_v_ff, hold_v_in, fin_ff, fin_in, rsp_valid_ff, rsp_valid_in;

   logic          out_free, can_push, push_en, out_load, item_done, cons_en;
   logic [CW-1:0] cons_c, src_c, buf_rd, buf_wdata;
   logic          src_replay, src_char, live, buf_we;
   logic [IW-1:0] src_idx, rd_idx;
   logic [SW-1:0] s_sel;
   logic          si_hit;
   logic [LW-1:0] eff_len, used;
   logic [lmdt_pkg::TYPE_W-1:0] eff_type;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      can_push   = !hold_v_ff || out_free;
      src_replay = (np_ff != '0);
      src_char   = src_replay || (head_valid && head.op == lmdt_pkg::OP_CHAR);
      src_idx    = IW'(h_ff + bc_ff[IW-1:0]);
      rd_idx     = (state_ff == ST_EMIT || state_ff == ST_CONS) ? h_ff : src_idx;
      buf_rd     = buf_ff[rd_idx];
      src_c      = src_replay ? buf_rd : head.symbol;
      si_hit     = si_pend_ff && si_rd_ff[IEW-1];
      eff_len    = si_hit ? si_len_ff : mlen_ff;
      eff_type   = si_hit ? si_rd_ff[lmdt_pkg::TYPE_W-1:0] : mtype_ff;
      live       = sok_ff && tt_rd_ff[EW-1] &&
                   (32'(tt_rd_ff[SW-1:0]) < lmdt_pkg::NUM_STATES);
      s_sel      = (bc_ff == '0) ? start_state : walk_ff;
      used       = (eff_len != '0) ? eff_len : LW'(1);
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;  h_in = h_ff;  bc_in = bc_ff;  np_in = np_ff;
      cnt_in = cnt_ff;  walk_in = walk_ff;  si_len_in = si_len_ff;  si_pend_in = 1'b0;
      mlen_in = eff_len;  mtype_in = eff_type;  line_in = line_ff;  col_in = col_ff;
      tline_in = tline_ff;  tcol_in = tcol_ff;  c_in = c_ff;  sok_in = sok_ff;
      qsrc_in = qsrc_ff;  owe_in = owe_ff;
      tt_we = 1'b0;  tt_waddr = '0;  tt_wdata = '0;  tt_re = 1'b0;  tt_raddr = '0;
      si_we = 1'b0;  si_waddr = '0;  si_wdata = '0;  si_re = 1'b0;  si_raddr = '0;
      pop = 1'b0;  push_en = 1'b0;  push_res = '0;  item_done = 1'b0;
      cons_en = 1'b0;  cons_c = c_ff;  buf_we = 1'b0;  buf_wdata = c_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            tt_we    = 1'b1;
            tt_waddr = clr_ff[AW-1:0];
            si_we    = 1'b1;
            si_waddr = clr_ff[SW-1:0];
            clr_in   = lmdt_pkg::CLR_W'(clr_ff + 1'b1);
            if (clr_ff[AW-1:0] == AW'(lmdt_pkg::TT_DEPTH - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (fin_ff) begin
               state_in = ST_FETCH;
            end else if (!src_replay && owe_ff) begin
               owe_in    = 1'b0;
               pop       = 1'b1;
               item_done = 1'b1;
            end else if (src_char) begin
               if (bc_ff == '0 && lmdt_pkg::is_blank(src_c)) begin
                  cons_en = 1'b1;
                  cons_c  = src_c;
                  if (src_replay) begin
                     h_in  = IW'(h_ff + 1'b1);
                     np_in = LW'(np_ff - 1'b1);
                  end else begin
                     pop       = 1'b1;
                     item_done = 1'b1;
                  end
               end else begin
                  if (bc_ff == '0) begin
                     tline_in = line_ff;
                     tcol_in  = col_ff;
                     mlen_in  = '0;
                     mtype_in = '0;
                  end
                  tt_re    = 1'b1;
                  tt_raddr = {s_sel, src_c};
                  c_in     = src_c;
                  sok_in   = 32'(s_sel) < lmdt_pkg::NUM_STATES;
                  qsrc_in  = !src_replay;
                  state_in = ST_LOOK;
               end
            end else if (head_valid) begin
               unique case (head.op)
                  lmdt_pkg::OP_EDGE: begin
                     tt_we    = 1'b1;
                     tt_waddr = {head.table_state, head.symbol};
                     tt_wdata = {head.edge_present, head.target_state};
                     pop      = 1'b1;
                     item_done = 1'b1;
                  end
                  lmdt_pkg::OP_INFO: begin
                     si_we    = 1'b1;
                     si_waddr = head.table_state;
                     si_wdata = {head.accepting, head.accepted_type};
                     pop      = 1'b1;
                     item_done = 1'b1;
                  end
                  lmdt_pkg::OP_END: begin
                     if (bc_ff != '0) begin
                        state_in = ST_EMIT;
                     end else if (can_push) begin
                        push_en                = 1'b1;
                        push_res.result_kind   = lmdt_pkg::RES_END;
                        push_res.start_line    = line_ff;
                        push_res.start_column  = col_ff;
                        pop       = 1'b1;
                        item_done = 1'b1;
                     end
                  end
                  default: begin
                     pop       = 1'b1;
                     item_done = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (live) begin
               walk_in    = tt_rd_ff[SW-1:0];
               buf_we     = 1'b1;
               bc_in      = LW'(bc_ff + 1'b1);
               si_re      = 1'b1;
               si_raddr   = tt_rd_ff[SW-1:0];
               si_pend_in = 1'b1;
               si_len_in  = LW'(bc_ff + 1'b1);
               if (bc_ff == LW'(lmdt_pkg::MAX_LOOKAHEAD - 1)) begin
                  state_in = ST_EMIT;
                  if (qsrc_ff) begin
                     owe_in = 1'b1;
                  end else begin
                     np_in = LW'(np_ff - 1'b1);
                  end
               end else begin
                  state_in = ST_FETCH;
                  if (qsrc_ff) begin
                     pop       = 1'b1;
                     item_done = 1'b1;
                  end else begin
                     np_in = LW'(np_ff - 1'b1);
                  end
               end
            end else if (bc_ff != '0) begin
               state_in = ST_EMIT;
            end else if (can_push) begin
               push_en                = 1'b1;
               push_res.result_kind   = lmdt_pkg::RES_ERROR;
               push_res.token_length  = LW'(1);
               push_res.start_line    = tline_ff;
               push_res.start_column  = tcol_ff;
               push_res.bad_symbol    = c_ff;
               cons_en  = 1'b1;
               state_in = ST_FETCH;
               if (qsrc_ff) begin
                  pop       = 1'b1;
                  item_done = 1'b1;
               end else begin
                  h_in  = IW'(h_ff + 1'b1);
                  np_in = LW'(np_ff - 1'b1);
               end
            end
         end
         ST_EMIT: begin
            if (can_push) begin
               push_en               = 1'b1;
               push_res.start_line   = tline_ff;
               push_res.start_column = tcol_ff;
               push_res.token_length = used;
               if (eff_len != '0) begin
                  push_res.result_kind = lmdt_pkg::RES_TOKEN;
                  push_res.token_type  = eff_type;
               end else begin
                  push_res.result_kind = lmdt_pkg::RES_ERROR;
                  push_res.bad_symbol  = buf_rd;
               end
               np_in    = LW'(np_ff + bc_ff - used);
               bc_in    = '0;
               cnt_in   = used;
               mlen_in  = '0;
               mtype_in = '0;
               state_in = ST_CONS;
            end
         end
         ST_CONS: begin
            cons_en = 1'b1;
            cons_c  = buf_rd;
            h_in    = IW'(h_ff + 1'b1);
            cnt_in  = LW'(cnt_ff - 1'b1);
            if (cnt_ff == LW'(1)) begin
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase

      if (cons_en) begin
         if (cons_c == lmdt_pkg::CH_NEWLINE) begin
            line_in = lmdt_pkg::sat_inc(line_ff);
            col_in  = PW'(1);
         end else begin
            col_in = lmdt_pkg::sat_inc(col_ff);
         end
      end

      out_load  = 1'b0;
      out_res   = hold_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      fin_in    = fin_ff;
      if (push_en) begin
         if (hold_v_ff) begin
            out_load     = 1'b1;
            out_res.last = 1'b0;
         end
         hold_in   = push_res;
         hold_v_in = 1'b1;
      end else if (fin_ff && hold_v_ff && out_free) begin
         out_load     = 1'b1;
         out_res.last = 1'b1;
         hold_v_in    = 1'b0;
      end
      if (item_done) begin
         fin_in = hold_v_in;
      end else if (!hold_v_in) begin
         fin_in = 1'b0;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = out_load ? out_res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (tt_we) begin
         tt_mem[tt_waddr] <= tt_wdata;
      end
      if (tt_re) begin
         tt_rd_ff <= tt_mem[tt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (si_we) begin
         si_mem[si_waddr] <= si_wdata;
      end
      if (si_re) begin
         si_rd_ff <= si_mem[si_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[src_idx] <= buf_wdata;
      end
      c_ff      <= c_in;
      sok_ff    <= sok_in;
      qsrc_ff   <= qsrc_in;
      si_len_ff <= si_len_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         h_ff         <= '0;
         bc_ff        <= '0;
         np_ff        <= '0;
         cnt_ff       <= '0;
         walk_ff      <= '0;
         mlen_ff      <= '0;
         mtype_ff     <= '0;
         line_ff      <= PW'(1);
         col_ff       <= PW'(1);
         tline_ff     <= PW'(1);
         tcol_ff      <= PW'(1);
         owe_ff       <= 1'b0;
         si_pend_ff   <= 1'b0;
         hold_v_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         h_ff         <= h_in;
         bc_ff        <= bc_in;
         np_ff        <= np_in;
         cnt_ff       <= cnt_in;
         walk_ff      <= walk_in;
         mlen_ff      <= mlen_in;
         mtype_ff     <= mtype_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         tline_ff     <= tline_in;
         tcol_ff      <= tcol_in;
         owe_ff       <= owe_in;
         si_pend_ff   <= si_pend_in;
         hold_v_ff    <= hold_v_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== bench/longest_match_dfa_tokenizer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_match_dfa_tokenizer_unit_test
// Self-checking bench for the longest-match DFA tokenizer.
//
// Loads a small lexer (identifiers, numbers, an arrow and a broken arrow)
// through table-write items, then streams characters through it under
// several start states. A behavioral lexer in the bench predicts every
// token, error and end-of-input result; the rsp_ channel is checked field
// by field in order. Directed rows cover the reset tables, blanks,
// backtracking and edge removal; random streams follow, with buffer
// overflow, bursty input, random output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module longest_match_dfa_tokenizer_unit_test;

   localparam logic [5:0] ST_IDENT = 6'd10;
   localparam logic [5:0] ST_NUM   = 6'd11;
   localparam logic [5:0] ST_DASH  = 6'd12;
   localparam logic [5:0] ST_ARROW = 6'd13;
   localparam logic [5:0] TY_IDENT = 6'd1;
   localparam logic [5:0] TY_NUM   = 6'd2;
   localparam logic [5:0] TY_ARROW = 6'd5;
   localparam int DIR_N     = 24;
   localparam int SETTLE    = 120;
   localparam int HOLD_LEN  = 400;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic [5:0] table_state;
      logic [5:0] target_state;
      logic       edge_present;
      logic       accepting;
      logic [5:0] accepted_type;
   } lex_item_type;

   typedef struct {
      lex_item_type         it;
      bit                   typed;
      lmdt_pkg::result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_symbol;
   logic [5:0]  req_table_state;
   logic [5:0]  req_target_state;
   logic        req_edge_present;
   logic        req_accepting;
   logic [5:0]  req_accepted_type;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [5:0]  rsp_token_type;
   logic [4:0]  rsp_token_length;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [7:0]  rsp_bad_symbol;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   longest_match_dfa_tokenizer_unit u_top (.*);

   // lexer shadow state
   logic [6:0]  edge_tbl [lmdt_pkg::TT_DEPTH];
   logic [6:0]  accept_tbl [lmdt_pkg::NUM_STATES];
   logic [7:0]  look_buf [lmdt_pkg::MAX_LOOKAHEAD];
   logic [7:0]  replay_q [$];
   int          look_cnt;
   logic [5:0]  cur_state;
   int          best_len;
   logic [5:0]  best_type;
   logic [15:0] line_no, col_no, tok_line, tok_col;
   logic [5:0]  scan_start;

   lmdt_pkg::result_type pending_tokens [$];
   int          fault_cnt;
   int          burst_left;
   int          hold_asked, hold_seen;
   dir_row_type dir_tbl [DIR_N];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic bit is_ws(logic [7:0] c);
      return c == lmdt_pkg::CH_SPACE || c == lmdt_pkg::CH_TAB ||
             c == lmdt_pkg::CH_CR || c == lmdt_pkg::CH_NEWLINE;
   endfunction

   function automatic void step_pos(logic [7:0] c);
      if (c == lmdt_pkg::CH_NEWLINE) begin
         if (line_no != 16'hFFFF) line_no++;
         col_no = 16'd1;
      end else if (col_no != 16'hFFFF) begin
         col_no++;
      end
   endfunction

   function automatic void add_token(logic [1:0] rk, logic [5:0] ty, int len,
                                     logic [7:0] bad);
      lmdt_pkg::result_type r;
      r.result_kind  = rk;
      r.token_type   = ty;
      r.token_length = len[4:0];
      r.start_line   = tok_line;
      r.start_column = tok_col;
      r.bad_symbol   = bad;
      r.last         = 1'b0;
      pending_tokens.push_back(r);
   endfunction

   function automatic void scan_chars(bit flush);
      logic [7:0] c;
      logic [6:0] e;
      int         used;
      bit         emit;
      while (1) begin
         emit = 1'b0;
         if (replay_q.size() == 0) begin
            if (!(flush && look_cnt > 0)) return;
            emit = 1'b1;
         end else begin
            c = replay_q[0];
            if (look_cnt == 0) begin
               if (is_ws(c)) begin
                  step_pos(c);
                  void'(replay_q.pop_front());
                  continue;
               end
               cur_state = scan_start;
               best_len  = 0;
               best_type = '0;
               tok_line  = line_no;
               tok_col   = col_no;
            end
            e = edge_tbl[{cur_state, c}];
            if (e[6]) begin
               cur_state = e[5:0];
               look_buf[look_cnt] = c;
               look_cnt++;
               void'(replay_q.pop_front());
               if (accept_tbl[cur_state][6]) begin
                  best_len  = look_cnt;
                  best_type = accept_tbl[cur_state][5:0];
               end
               if (look_cnt == lmdt_pkg::MAX_LOOKAHEAD) emit = 1'b1;
            end else if (look_cnt == 0) begin
               add_token(lmdt_pkg::RES_ERROR, '0, 1, c);
               step_pos(c);
               void'(replay_q.pop_front());
            end else begin
               emit = 1'b1;
            end
         end
         if (emit) begin
            if (best_len > 0) begin
               add_token(lmdt_pkg::RES_TOKEN, best_type, best_len, 8'd0);
               used = best_len;
            end else begin
               add_token(lmdt_pkg::RES_ERROR, '0, 1, look_buf[0]);
               used = 1;
            end
            for (int i = 0; i < used; i++) step_pos(look_buf[i]);
            for (int i = look_cnt - 1; i >= used; i--) replay_q.push_front(look_buf[i]);
            look_cnt  = 0;
            best_len  = 0;
            best_type = '0;
            cur_state = scan_start;
         end
      end
   endfunction

   function automatic void lex_step(lex_item_type it);
      int prior_cnt;
      prior_cnt = pending_tokens.size();
      case (it.kind)
         lmdt_pkg::KIND_EDGE:
            edge_tbl[{it.table_state, it.symbol}] = {it.edge_present, it.target_state};
         lmdt_pkg::KIND_INFO:
            accept_tbl[it.table_state] = {it.accepting, it.accepted_type};
         lmdt_pkg::KIND_CHAR: begin
            replay_q.push_back(it.symbol);
            scan_chars(1'b0);
         end
         default: begin
            scan_chars(1'b1);
            tok_line = line_no;
            tok_col  = col_no;
            add_token(lmdt_pkg::RES_END, '0, 0, 8'd0);
         end
      endcase
      if (pending_tokens.size() > prior_cnt)
         pending_tokens[pending_tokens.size() - 1].last = 1'b1;
   endfunction

   function automatic lex_item_type mk_item(logic [1:0] k, logic [7:0] s, logic [5:0] ts,
                                            logic [5:0] tg, logic ep, logic ac,
                                            logic [5:0] ty);
      lex_item_type it;
      it.kind = k; it.symbol = s; it.table_state = ts; it.target_state = tg;
      it.edge_present = ep; it.accepting = ac; it.accepted_type = ty;
      return it;
   endfunction

   function automatic lex_item_type mk_noise(logic [1:0] k);
      return mk_item(k, 8'($urandom), 6'($urandom), 6'($urandom), 1'($urandom),
                     1'($urandom), 6'($urandom));
   endfunction

   function automatic lex_item_type ch(logic [7:0] s);
      lex_item_type it;
      it = mk_noise(lmdt_pkg::KIND_CHAR);
      it.symbol = s;
      return it;
   endfunction

   function automatic lmdt_pkg::result_type mk_result(logic [1:0] rk, logic [15:0] col,
                                                      logic [7:0] bad);
      lmdt_pkg::result_type r;
      r.result_kind = rk; r.token_type = '0;
      r.token_length = (rk == lmdt_pkg::RES_ERROR) ? 5'd1 : 5'd0;
      r.start_line = 16'd1; r.start_column = col; r.bad_symbol = bad; r.last = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         return $urandom_range(0, 8);
      end
      burst_left--;
      return 0;
   endfunction

   task automatic send_item(input lex_item_type it);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= it.kind;
      req_symbol        <= it.symbol;
      req_table_state   <= it.table_state;
      req_target_state  <= it.target_state;
      req_edge_present  <= it.edge_present;
      req_accepting     <= it.accepting;
      req_accepted_type <= it.accepted_type;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      lex_step(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_start_state(input logic [5:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= lmdt_pkg::CSR_START_STATE; csr_pwdata <= {26'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      scan_start = v;
      cur_state  = v;
      csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[5:0] !== v) begin
         $display("%0t: start_state read expected %0h actual %0h", $time, v, csr_prdata[5:0]);
         fault_cnt++;
      end
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic load_lexer(input logic [5:0] s);
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "a", s,        ST_IDENT, 1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "a", ST_IDENT, ST_IDENT, 1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "1", ST_IDENT, ST_IDENT, 1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "1", s,        ST_NUM,   1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "1", ST_NUM,   ST_NUM,   1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, "-", s,        ST_DASH,  1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_EDGE, ">", ST_DASH,  ST_ARROW, 1'b1, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_INFO, 8'd0, ST_IDENT, 6'd0, 1'b0, 1'b1, TY_IDENT));
      send_item(mk_item(lmdt_pkg::KIND_INFO, 8'd0, ST_NUM,   6'd0, 1'b0, 1'b1, TY_NUM));
      send_item(mk_item(lmdt_pkg::KIND_INFO, 8'd0, ST_DASH,  6'd0, 1'b0, 1'b0, 6'd0));
      send_item(mk_item(lmdt_pkg::KIND_INFO, 8'd0, ST_ARROW, 6'd0, 1'b0, 1'b1, TY_ARROW));
   endtask

   // one lexeme-shaped run of items, occasionally noise
   task automatic send_run(output int n);
      int r, len;
      r = $urandom_range(0, 99);
      n = 0;
      if (r < 30) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
         send_item(ch("a"));
         for (int i = 1; i < len; i++) send_item(ch($urandom_range(0, 1) ? "a" : "1"));
         n = len;
      end else if (r < 45) begin
         len = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(1, 5);
         for (int i = 0; i < len; i++) send_item(ch("1"));
         n = len;
      end else if (r < 55) begin
         send_item(ch("-")); send_item(ch(">")); n = 2;
      end else if (r < 60) begin
         send_item(ch("-")); send_item(ch(8'($urandom_range(0, 255)))); n = 2;
      end else if (r < 72) begin
         case ($urandom_range(0, 3))
            0: send_item(ch(lmdt_pkg::CH_SPACE));
            1: send_item(ch(lmdt_pkg::CH_TAB));
            2: send_item(ch(lmdt_pkg::CH_CR));
            default: send_item(ch(lmdt_pkg::CH_NEWLINE));
         endcase
      end else if (r < 80) begin
         send_item(ch(8'($urandom_range(0, 255)))); n = 1;
      end else if (r < 85) begin
         send_item(mk_noise(lmdt_pkg::KIND_EDGE));
         n = 1;
      end else if (r < 89) begin
         send_item(mk_noise(lmdt_pkg::KIND_INFO));
         n = 1;
      end else if (r < 93) begin
         send_item(mk_noise(lmdt_pkg::KIND_END));
         n = 1;
      end else begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            case ($urandom_range(0, 4))
               0: send_item(ch("a"));
               1: send_item(ch("1"));
               2: send_item(ch("-"));
               3: send_item(ch(">"));
               default: send_item(ch(lmdt_pkg::CH_SPACE));
            endcase
         n = len;
      end
   endtask

   // receiver stall pattern
   initial begin
      int mode, cyc;
      rsp_ready <= 1'b0;
      mode = 0;
      cyc  = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end
         if (cyc % 50 == 0) mode = $urandom_range(0, 3);
         cyc++;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic match_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fault_cnt++;
      end
   endtask

   // result checker
   initial begin
      lmdt_pkg::result_type w;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_tokens.size() == 0) begin
               $display("%0t: unexpected result transfer kind %0h", $time, rsp_result_kind);
               fault_cnt++;
            end else begin
               w = pending_tokens.pop_front();
               match_field("result_kind",  w.result_kind,  rsp_result_kind);
               match_field("token_type",   w.token_type,   rsp_token_type);
               match_field("token_length", w.token_length, rsp_token_length);
               match_field("start_line",   w.start_line,   rsp_start_line);
               match_field("start_column", w.start_column, rsp_start_column);
               match_field("bad_symbol",   w.bad_symbol,   rsp_bad_symbol);
               match_field("last",         w.last,         rsp_last);
            end
         end
      end
   end

   initial begin
      logic [5:0] phase_start [3];
      int         sent, n;

      reset <= 1'b1;
      req_valid <= 1'b0; req_kind <= lmdt_pkg::KIND_CHAR; req_symbol <= '0;
      req_table_state <= '0; req_target_state <= '0; req_edge_present <= 1'b0;
      req_accepting <= 1'b0; req_accepted_type <= '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= lmdt_pkg::CSR_START_STATE; csr_pwdata <= '0;
      for (int i = 0; i < lmdt_pkg::TT_DEPTH; i++) edge_tbl[i] = '0;
      for (int i = 0; i < lmdt_pkg::NUM_STATES; i++) accept_tbl[i] = '0;
      look_cnt = 0; cur_state = '0; best_len = 0; best_type = '0;
      line_no = 16'd1; col_no = 16'd1; tok_line = 16'd1; tok_col = 16'd1;
      scan_start = '0; fault_cnt = 0; burst_left = 0;
      hold_asked = 0; hold_seen = 0;

      for (int i = 0; i < DIR_N; i++) dir_tbl[i].typed = 1'b0;
      dir_tbl[0].it  = ch("x");
      dir_tbl[1].it  = ch(8'hFF);
      dir_tbl[2].it  = ch(8'h00);
      dir_tbl[3].it  = mk_item(lmdt_pkg::KIND_END, 8'hFF, 6'h3F, 6'h3F, 1'b1, 1'b1, 6'h3F);
      dir_tbl[0].typed = 1'b1;
      dir_tbl[0].want  = mk_result(lmdt_pkg::RES_ERROR, 16'd1, "x");
      dir_tbl[1].typed = 1'b1;
      dir_tbl[1].want  = mk_result(lmdt_pkg::RES_ERROR, 16'd2, 8'hFF);
      dir_tbl[2].typed = 1'b1;
      dir_tbl[2].want  = mk_result(lmdt_pkg::RES_ERROR, 16'd3, 8'h00);
      dir_tbl[3].typed = 1'b1;
      dir_tbl[3].want  = mk_result(lmdt_pkg::RES_END,   16'd4, 8'h00);
      dir_tbl[4].it  = ch("a");
      dir_tbl[5].it  = ch("a");
      dir_tbl[6].it  = ch("1");
      dir_tbl[7].it  = ch(lmdt_pkg::CH_SPACE);
      dir_tbl[8].it  = ch("-");
      dir_tbl[9].it  = ch("x");
      dir_tbl[10].it = ch(lmdt_pkg::CH_NEWLINE);
      dir_tbl[11].it = ch(lmdt_pkg::CH_TAB);
      dir_tbl[12].it = ch(lmdt_pkg::CH_CR);
      dir_tbl[13].it = ch("1");
      dir_tbl[14].it = ch(8'h00);
      dir_tbl[15].it = ch("-");
      dir_tbl[16].it = ch(">");
      dir_tbl[17].it = mk_item(lmdt_pkg::KIND_EDGE, "1", 6'd0, 6'd0, 1'b0, 1'b0, 6'd0);
      dir_tbl[18].it = ch("1");
      dir_tbl[19].it = mk_item(lmdt_pkg::KIND_INFO, 8'd0, ST_NUM, 6'd0, 1'b0, 1'b0, 6'h3F);
      dir_tbl[20].it = mk_item(lmdt_pkg::KIND_EDGE, "1", 6'd0, ST_NUM, 1'b1, 1'b0, 6'd0);
      dir_tbl[21].it = ch("1");
      dir_tbl[22].it = ch("1");
      dir_tbl[23].it = mk_item(lmdt_pkg::KIND_END, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0, 6'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_start_state(6'd0);
      for (int i = 0; i < DIR_N; i++) begin
         if (i == 4) load_lexer(6'd0);
         send_item(dir_tbl[i].it);
         if (dir_tbl[i].typed) begin
            void'(pending_tokens.pop_back());
            pending_tokens.push_back(dir_tbl[i].want);
         end
      end
      drain();

      phase_start[0] = 6'd63;
      phase_start[1] = 6'($urandom_range(20, 62));
      phase_start[2] = 6'd0;
      for (int p = 0; p < 3; p++) begin
         set_start_state(phase_start[p]);
         load_lexer(phase_start[p]);
         sent = 0;
         while (sent < 80) begin
            if (p == 1 && sent >= 30 && hold_asked == 0) hold_asked = 1;
            send_run(n);
            sent += n;
         end
         send_item(mk_item(lmdt_pkg::KIND_END, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0, 6'd0));
         drain();
      end

      if (fault_cnt == 0 && pending_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
